// ===== rtl/fdl_pkg.sv =====
// Package with the shared constants, types and helpers of the fractional delay line.
`timescale 1ns / 1ps

package fdl_pkg;

	// Store geometry and sample format.
	localparam int MAX_LOG2_LEN = 12;
	localparam int SAMPLE_BITS  = 16;
	localparam int LEN_BITS     = 4;
	localparam int DELAY_BITS   = 12;
	localparam int FRAC_BITS    = 16;
	localparam int MODE_BITS    = 2;

	localparam logic [LEN_BITS-1:0] LENGTH_RESET = LEN_BITS'(9);

	// Request modes.
	localparam logic [MODE_BITS-1:0] MODE_PUSH = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_READ = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_PEAK = 2'd2;

	// Result kinds.
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_PEAK = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ2,
		ST_DIFF,
		ST_PROD,
		ST_ROUND,
		ST_PEAK
	} state_t;

	// Index mask of the active ring; the length is clamped to the legal range.
	function automatic logic [MAX_LOG2_LEN-1:0] active_mask(logic [LEN_BITS-1:0] len);
		int l;
		l = int'(len);
		if (l < 1) l = 1;
		if (l > MAX_LOG2_LEN) l = MAX_LOG2_LEN;
		return MAX_LOG2_LEN'((1 << l) - 1);
	endfunction

endpackage

// ===== rtl/fdl_ram.sv =====
// Simple dual-port synchronous RAM with one registered read port.
`timescale 1ns / 1ps

module fdl_ram #(
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port: the data for an address is there in the cycle after it is presented.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/fractional_delay_line.sv =====
// Top level of the fractional delay line: sequencer, ring pointer and interpolation datapath.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. A push is written in the cycle it
// is taken and gives no result. A delayed read runs through the states READ2, DIFF, PROD
// and ROUND and then the done register; the two store reads go through the one read port
// of the sample RAM, followed by a subtract, a multiply and a rounding stage. A peak query
// reads every active entry once. Results appear for exactly one cycle with done high and
// must be taken then. After reset, and after every write of length_log2, the block clears
// the active part of the store one entry a cycle and holds busy high meanwhile. Mode 3 is
// ignored. The length register is always ready.

module fractional_delay_line (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [fdl_pkg::MODE_BITS-1:0]        mode,
	input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [fdl_pkg::DELAY_BITS-1:0]       delay_whole,
	input  logic [fdl_pkg::FRAC_BITS-1:0]        delay_fraction,
	output logic                                 done,
	output logic signed [fdl_pkg::SAMPLE_BITS-1:0] value,
	output logic                                 result_kind,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fdl_pkg::LEN_BITS-1:0]         cfg_data
);

	localparam int AW = fdl_pkg::MAX_LOG2_LEN;
	localparam int SB = fdl_pkg::SAMPLE_BITS;
	localparam int FB = fdl_pkg::FRAC_BITS;
	localparam int PW = SB + FB + 2;
	localparam logic signed [PW-1:0] ROUND_HALF =
		{{(PW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

	fdl_pkg::state_t state_q, state_d;

	logic [fdl_pkg::LEN_BITS-1:0] length_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] scan_q;
	logic          done_q;

	logic [AW-1:0]        i2_q;
	logic [FB-1:0]        frac_q;
	logic signed [SB-1:0] y1_q;
	logic signed [SB:0]   diff_q;
	logic signed [PW-1:0] prod_q;
	logic signed [SB-1:0] best_q;
	logic signed [SB-1:0] value_q;
	logic                 kind_q;

	logic [AW-1:0]        mask_c;
	logic                 accept_c;
	logic [AW-1:0]        i1_c;
	logic                 we_c;
	logic [AW-1:0]        waddr_c;
	logic [SB-1:0]        wdata_c;
	logic [AW-1:0]        raddr_c;
	logic [SB-1:0]        rdata;
	logic signed [SB:0]   diff_c;
	logic signed [PW-1:0] rnd_c;
	logic signed [PW-1:0] step_c;
	logic signed [SB-1:0] peak_c;
	logic                 peak_last_c;

	// Sample store.
	fdl_ram #(
		.ADDR_BITS(AW),
		.DATA_BITS(SB)
	) u_ram (
		.clk  (clk),
		.we   (we_c),
		.waddr(waddr_c),
		.wdata(wdata_c),
		.raddr(raddr_c),
		.rdata(rdata)
	);

	// Ring geometry and the address of the delayed sample.
	assign mask_c      = fdl_pkg::active_mask(length_q);
	assign busy        = (state_q != fdl_pkg::ST_IDLE);
	assign accept_c    = start && !busy;
	assign i1_c        = (wp_q - AW'(1) - (AW'(delay_whole) & mask_c)) & mask_c;
	assign peak_last_c = (scan_q == mask_c);

	// Datapath arithmetic: difference, rounding and running maximum.
	assign diff_c = {rdata[SB-1], rdata} - {y1_q[SB-1], y1_q};
	assign rnd_c  = prod_q + ROUND_HALF;
	assign step_c = rnd_c >>> FB;
	assign peak_c = ((scan_q == '0) || ($signed(rdata) > best_q)) ? $signed(rdata) : best_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdl_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d = state_q;
		we_c    = 1'b0;
		waddr_c = wp_q & mask_c;
		wdata_c = sample;
		raddr_c = i2_q;
		unique case (state_q)
			fdl_pkg::ST_CLEAR: begin
				we_c    = 1'b1;
				waddr_c = clr_q;
				wdata_c = '0;
				if (clr_q == mask_c) state_d = fdl_pkg::ST_IDLE;
			end
			fdl_pkg::ST_IDLE: begin
				if (accept_c) begin
					unique case (mode)
						fdl_pkg::MODE_PUSH: begin
							we_c = 1'b1;
						end
						fdl_pkg::MODE_READ: begin
							raddr_c = i1_c;
							state_d = fdl_pkg::ST_READ2;
						end
						fdl_pkg::MODE_PEAK: begin
							raddr_c = '0;
							state_d = fdl_pkg::ST_PEAK;
						end
						default: begin
						end
					endcase
				end
			end
			fdl_pkg::ST_READ2: begin
				raddr_c = i2_q;
				state_d = fdl_pkg::ST_DIFF;
			end
			fdl_pkg::ST_DIFF: begin
				state_d = fdl_pkg::ST_PROD;
			end
			fdl_pkg::ST_PROD: begin
				state_d = fdl_pkg::ST_ROUND;
			end
			fdl_pkg::ST_ROUND: begin
				state_d = fdl_pkg::ST_IDLE;
			end
			fdl_pkg::ST_PEAK: begin
				raddr_c = (scan_q + AW'(1)) & mask_c;
				if (peak_last_c) state_d = fdl_pkg::ST_IDLE;
			end
			default: begin
				state_d = fdl_pkg::ST_CLEAR;
			end
		endcase
		// A length write restarts the clearing pass.
		if (cfg_valid) state_d = fdl_pkg::ST_CLEAR;
	end

	// Control registers: length, write pointer, clear and scan counters, result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= fdl_pkg::LENGTH_RESET;
			wp_q     <= '0;
			clr_q    <= '0;
			scan_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == fdl_pkg::ST_ROUND) ||
				((state_q == fdl_pkg::ST_PEAK) && peak_last_c);
			if (cfg_valid) begin
				length_q <= cfg_data;
				wp_q     <= '0;
				clr_q    <= '0;
			end else begin
				if (state_q == fdl_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
				if (accept_c && (mode == fdl_pkg::MODE_PUSH)) begin
					wp_q <= (wp_q + AW'(1)) & mask_c;
				end
			end
			if (accept_c && (mode == fdl_pkg::MODE_PEAK)) begin
				scan_q <= '0;
			end else if (state_q == fdl_pkg::ST_PEAK) begin
				scan_q <= scan_q + AW'(1);
			end
		end
	end

	// Payload registers of the interpolation and peak paths.
	always_ff @(posedge clk) begin
		if (accept_c && (mode == fdl_pkg::MODE_READ)) begin
			i2_q   <= (i1_c - AW'(1)) & mask_c;
			frac_q <= delay_fraction;
		end
		if (state_q == fdl_pkg::ST_READ2) y1_q <= $signed(rdata);
		if (state_q == fdl_pkg::ST_DIFF) diff_q <= diff_c;
		if (state_q == fdl_pkg::ST_PROD) begin
			prod_q <= PW'($signed({1'b0, frac_q})) * PW'(diff_q);
		end
		if (state_q == fdl_pkg::ST_ROUND) begin
			value_q <= y1_q + $signed(step_c[SB-1:0]);
			kind_q  <= fdl_pkg::KIND_READ;
		end
		if (state_q == fdl_pkg::ST_PEAK) begin
			best_q <= peak_c;
			if (peak_last_c) begin
				value_q <= peak_c;
				kind_q  <= fdl_pkg::KIND_PEAK;
			end
		end
	end

	assign done        = done_q;
	assign value       = value_q;
	assign result_kind = kind_q;
	assign cfg_ready   = 1'b1;

`ifndef NO_ASSERTIONS
	// The store is written only by the clearing pass or by an accepted push.
	assert property (@(posedge clk) disable iff (!arst_n)
		we_c |-> (state_q == fdl_pkg::ST_CLEAR) ||
			(accept_c && (mode == fdl_pkg::MODE_PUSH)))
		else $error("store written outside clear or push");

	// The clearing pass writes zeros.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdl_pkg::ST_CLEAR) |-> (we_c && (wdata_c == '0)))
		else $error("clearing pass wrote a nonzero word");

	// The write pointer stays inside the active ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		((wp_q & ~mask_c) == '0))
		else $error("write pointer outside the active ring");

	// A result follows only the rounding stage or the last peak read.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == fdl_pkg::ST_ROUND) ||
			($past(state_q) == fdl_pkg::ST_PEAK))
		else $error("result strobe without a finishing request");

	// Two results never come in adjacent cycles.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe high for two cycles");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the fractional delay line: pushes, delayed reads and peak scans.
`timescale 1ns / 1ps

module tb;

	// Mode 3 has no meaning; the block must ignore it.
	localparam logic [fdl_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 40_000_000;
	localparam int RING_DEPTH  = 1 << fdl_pkg::MAX_LOG2_LEN;

	typedef struct {
		logic signed [fdl_pkg::SAMPLE_BITS-1:0] value;
		logic                                   kind;
	} tap_result_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   start = 1'b0;
	logic [fdl_pkg::MODE_BITS-1:0]          mode = fdl_pkg::MODE_PUSH;
	logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample = '0;
	logic [fdl_pkg::DELAY_BITS-1:0]         delay_whole = '0;
	logic [fdl_pkg::FRAC_BITS-1:0]          delay_fraction = '0;
	logic                                   cfg_valid = 1'b0;
	logic [fdl_pkg::LEN_BITS-1:0]           cfg_data = '0;
	logic                                   busy;
	logic                                   done;
	logic signed [fdl_pkg::SAMPLE_BITS-1:0] value;
	logic                                   result_kind;
	logic                                   cfg_ready;

	// Local copy of the ring, its write pointer and the length register.
	logic signed [fdl_pkg::SAMPLE_BITS-1:0] ring_copy [RING_DEPTH];
	logic [fdl_pkg::MAX_LOG2_LEN-1:0]       ring_wp;
	logic [fdl_pkg::LEN_BITS-1:0]           ring_len;

	tap_result_t tap_results_q[$];

	int mismatches = 0;
	int cycles = 0;
	int n_push = 0;
	int n_read = 0;
	int n_peak = 0;
	int n_ignored = 0;
	int n_lengths = 0;

	fractional_delay_line DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.sample         (sample),
		.delay_whole    (delay_whole),
		.delay_fraction (delay_fraction),
		.done           (done),
		.value          (value),
		.result_kind    (result_kind),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #6 clk = ~clk;

	// Run guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Index mask of the ring for a given length register; 0 behaves as 1, above the maximum
	// behaves as the maximum.
	function automatic logic [fdl_pkg::MAX_LOG2_LEN-1:0] ring_mask(
			input logic [fdl_pkg::LEN_BITS-1:0] len);
		logic [fdl_pkg::LEN_BITS-1:0] eff;
		logic [fdl_pkg::MAX_LOG2_LEN:0] span;
		eff = (len == 0) ? fdl_pkg::LEN_BITS'(1) :
			(len > fdl_pkg::MAX_LOG2_LEN) ? fdl_pkg::LEN_BITS'(fdl_pkg::MAX_LOG2_LEN) : len;
		span = (fdl_pkg::MAX_LOG2_LEN + 1)'(1) << eff;
		return fdl_pkg::MAX_LOG2_LEN'(span - 1);
	endfunction

	task automatic clear_ring_copy();
		foreach (ring_copy[i]) ring_copy[i] = '0;
		ring_wp = '0;
	endtask

	// Apply one accepted request to the local ring and queue the result it must produce.
	task automatic advance_ring_copy(input logic [fdl_pkg::MODE_BITS-1:0] m,
			input logic signed [fdl_pkg::SAMPLE_BITS-1:0] s,
			input logic [fdl_pkg::DELAY_BITS-1:0] dw,
			input logic [fdl_pkg::FRAC_BITS-1:0] f);
		logic [fdl_pkg::MAX_LOG2_LEN-1:0] msk;
		logic [fdl_pkg::MAX_LOG2_LEN-1:0] d;
		logic [fdl_pkg::MAX_LOG2_LEN-1:0] newer_idx;
		logic [fdl_pkg::MAX_LOG2_LEN-1:0] older_idx;
		logic signed [fdl_pkg::SAMPLE_BITS-1:0] newer;
		logic signed [fdl_pkg::SAMPLE_BITS-1:0] older;
		longint prod;
		tap_result_t r;
		msk = ring_mask(ring_len);
		case (m)
			fdl_pkg::MODE_PUSH: begin
				ring_copy[ring_wp & msk] = s;
				ring_wp = (ring_wp + fdl_pkg::MAX_LOG2_LEN'(1)) & msk;
				n_push++;
			end
			fdl_pkg::MODE_READ: begin
				d = dw & msk;
				newer_idx = (ring_wp - fdl_pkg::MAX_LOG2_LEN'(1) - d) & msk;
				older_idx = (ring_wp - fdl_pkg::MAX_LOG2_LEN'(2) - d) & msk;
				newer = ring_copy[newer_idx];
				older = ring_copy[older_idx];
				// Rounded step toward the older sample; the arithmetic shift floors.
				prod = longint'(f) * (longint'(older) - longint'(newer)) + 64'sd32768;
				r.value = fdl_pkg::SAMPLE_BITS'(longint'(newer) + (prod >>> 16));
				r.kind = fdl_pkg::KIND_READ;
				tap_results_q.push_back(r);
				n_read++;
			end
			fdl_pkg::MODE_PEAK: begin
				r.value = ring_copy[0];
				for (int i = 1; i <= int'(msk); i++) begin
					if (ring_copy[i] > r.value) r.value = ring_copy[i];
				end
				r.kind = fdl_pkg::KIND_PEAK;
				tap_results_q.push_back(r);
				n_peak++;
			end
			default: n_ignored++;
		endcase
	endtask

	// Result checker: every strobed result must match the oldest outstanding expectation.
	always @(posedge clk) begin
		tap_result_t exp_r;
		if (arst_n && done === 1'b1) begin
			if (tap_results_q.size() == 0) begin
				$error("unexpected result: value %0d, result_kind %0d", value, result_kind);
				mismatches++;
			end else begin
				exp_r = tap_results_q.pop_front();
				if (value !== exp_r.value) begin
					$error("value: expected %0d, got %0d", exp_r.value, value);
					mismatches++;
				end
				if (result_kind !== exp_r.kind) begin
					$error("result_kind: expected %0d, got %0d", exp_r.kind, result_kind);
					mismatches++;
				end
			end
		end
	end

	// Present one request and hold it until the block takes it.
	task automatic issue_request(input logic [fdl_pkg::MODE_BITS-1:0] m,
			input logic signed [fdl_pkg::SAMPLE_BITS-1:0] s,
			input logic [fdl_pkg::DELAY_BITS-1:0] dw,
			input logic [fdl_pkg::FRAC_BITS-1:0] f);
		start <= 1'b1;
		mode <= m;
		sample <= s;
		delay_whole <= dw;
		delay_fraction <= f;
		do @(posedge clk); while (busy !== 1'b0);
		advance_ring_copy(m, s, dw, f);
	endtask

	// Drop start, wait for all outstanding results, then let any push settle.
	task automatic settle_block();
		start <= 1'b0;
		@(posedge clk);
		while (tap_results_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Length write; the block clears its store, so the local copy does as well.
	task automatic write_length(input logic [fdl_pkg::LEN_BITS-1:0] len);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		ring_len = len;
		clear_ring_copy();
		n_lengths++;
	endtask

	// Idle between requests: mostly none or short, sometimes long.
	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// One random request; peak scans are rarer on long rings since they take a cycle per entry.
	task automatic random_request(output bit counted);
		int r;
		int peak_pct;
		logic [fdl_pkg::MAX_LOG2_LEN-1:0] msk;
		logic [fdl_pkg::MODE_BITS-1:0] m;
		logic signed [fdl_pkg::SAMPLE_BITS-1:0] s;
		logic [fdl_pkg::DELAY_BITS-1:0] dw;
		logic [fdl_pkg::FRAC_BITS-1:0] f;
		msk = ring_mask(ring_len);
		peak_pct = (msk >= 1023) ? 1 : 6;
		r = $urandom_range(0, 99);
		m = (r < 50) ? fdl_pkg::MODE_PUSH : (r < 94 - peak_pct) ? fdl_pkg::MODE_READ :
			(r < 94) ? fdl_pkg::MODE_PEAK : MODE_UNUSED;
		case ($urandom_range(0, 7))
			0: s = 16'sh7FFF;
			1: s = 16'sh8000;
			2: s = -16'sd1;
			default: s = fdl_pkg::SAMPLE_BITS'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0: dw = fdl_pkg::DELAY_BITS'($urandom);
			1: dw = fdl_pkg::DELAY_BITS'($urandom_range(0, 7));
			default: dw = fdl_pkg::DELAY_BITS'(msk - $urandom_range(0, 3));
		endcase
		case ($urandom_range(0, 5))
			0: f = '0;
			1: f = 16'hFFFF;
			2: f = 16'h8000;
			default: f = fdl_pkg::FRAC_BITS'($urandom);
		endcase
		issue_request(m, s, dw, f);
		counted = (m != MODE_UNUSED);
	endtask

	// Fresh store after reset, then taps at the ends of the ring and the wrap of the older
	// sample.
	task automatic test_directed_taps();
		issue_request(fdl_pkg::MODE_PEAK, '0, '0, '0);
		issue_request(fdl_pkg::MODE_PUSH, 16'sh7FFF, '0, '0);
		issue_request(fdl_pkg::MODE_PUSH, 16'sh8000, '0, '0);
		issue_request(fdl_pkg::MODE_PUSH, 16'sd0, '0, '0);
		issue_request(fdl_pkg::MODE_PUSH, 16'sd1, '0, '0);
		issue_request(fdl_pkg::MODE_PUSH, -16'sd1, '0, '0);
		issue_request(fdl_pkg::MODE_READ, '0, 12'd0, 16'h0000);
		issue_request(fdl_pkg::MODE_READ, '0, 12'd0, 16'hFFFF);
		issue_request(fdl_pkg::MODE_READ, '0, 12'd1, 16'h8000);
		issue_request(fdl_pkg::MODE_READ, '0, 12'd3, 16'hFFFF);
		issue_request(fdl_pkg::MODE_READ, '0, 12'd3, 16'h8000);
		issue_request(fdl_pkg::MODE_READ, '0, 12'd4, 16'd1000);
		issue_request(fdl_pkg::MODE_READ, '0, 12'hFFF, 16'h0001);
		issue_request(MODE_UNUSED, 16'sh5555, 12'hAAA, 16'h5555);
		issue_request(fdl_pkg::MODE_PEAK, '0, '0, '0);
	endtask

	// Length register at and beyond both ends of its range, with an all-negative peak.
	task automatic test_length_extremes();
		settle_block();
		write_length(4'd0);
		issue_request(fdl_pkg::MODE_PUSH, -16'sd5, '0, '0);
		issue_request(fdl_pkg::MODE_PUSH, -16'sd7, '0, '0);
		issue_request(fdl_pkg::MODE_PEAK, '0, '0, '0);
		issue_request(fdl_pkg::MODE_READ, '0, 12'd0, 16'h0000);
		issue_request(fdl_pkg::MODE_READ, '0, 12'd1, 16'hFFFF);
		settle_block();
		write_length(4'd15);
		issue_request(fdl_pkg::MODE_PEAK, '0, '0, '0);
		issue_request(fdl_pkg::MODE_PUSH, 16'sd100, '0, '0);
		issue_request(fdl_pkg::MODE_READ, '0, 12'hFFF, 16'h0000);
	endtask

	// Random traffic over a series of lengths; some phases run without any idle cycles.
	task automatic test_random_traffic();
		logic [fdl_pkg::LEN_BITS-1:0] lengths [10] = '{4'd1, 4'd3, 4'd12, 4'd0, 4'd2, 4'd15,
			4'd5, 4'd7, 4'd4, 4'd9};
		int counted_items;
		bit counted;
		for (int p = 0; p < 10; p++) begin
			settle_block();
			write_length(lengths[p]);
			counted_items = 0;
			while (counted_items < 160) begin
				random_request(counted);
				if (counted) counted_items++;
				if (p % 3 != 1) idle_gap();
			end
		end
	endtask

	initial begin
		ring_len = fdl_pkg::LENGTH_RESET;
		clear_ring_copy();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_taps();
		test_length_extremes();
		test_random_traffic();
		settle_block();
		repeat (16) @(posedge clk);
		$display("Covered %0d pushes, %0d delayed reads, %0d peak scans, %0d ignored requests",
			n_push, n_read, n_peak, n_ignored);
		$display("across %0d length writes; %0d mismatches seen", n_lengths, mismatches);
		if (mismatches == 0 && tap_results_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fdl_pkg.sv
rtl/fdl_ram.sv
rtl/fractional_delay_line.sv
tb/tb.sv
